/* design/mbl_pkg.sv */
// ----------------------------------------------------------------------------
// mbl_pkg: shared types and constants of the multichannel biquad low-pass
// Sample and coefficient formats, beat structs, history entry layout and
// register map of the configuration port.
// ----------------------------------------------------------------------------
package mbl_pkg;

  // Formats
  localparam int CHANNELS       = 7;
  localparam int SAMPLE_WIDTH   = 24;
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_W         = COEF_FRAC_BITS + 2;
  localparam int CHAN_W         = 3;
  localparam int ADDR_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PROD_W         = SAMPLE_WIDTH + COEF_W;
  // five products summed: three guard bits
  localparam int ACC_W          = PROD_W + 3;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_CASCADE = 3'd0,
    REG_B0      = 3'd1,
    REG_B1      = 3'd2,
    REG_B2      = 3'd3,
    REG_A1      = 3'd4,
    REG_A2      = 3'd5
  } reg_idx_t;

  // Reset coefficients, Q2.16 (Butterworth low-pass)
  localparam logic signed [COEF_W-1:0] B0_RESET = COEF_W'(4424);
  localparam logic signed [COEF_W-1:0] B1_RESET = COEF_W'(8841);
  localparam logic signed [COEF_W-1:0] B2_RESET = COEF_W'(4424);
  localparam logic signed [COEF_W-1:0] A1_RESET = COEF_W'(-74908);
  localparam logic signed [COEF_W-1:0] A2_RESET = COEF_W'(27054);

  // Beats
  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic [CHAN_W-1:0]              channel;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic [CHAN_W-1:0]              channel_out;
  } out_beat_t;

  // One section's history for one channel
  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] x1;
    logic signed [SAMPLE_WIDTH-1:0] x2;
    logic signed [SAMPLE_WIDTH-1:0] y1;
    logic signed [SAMPLE_WIDTH-1:0] y2;
  } hist_t;

  localparam int HIST_W = $bits(hist_t);

endpackage

/* design/mbl_ram.sv */
// ----------------------------------------------------------------------------
// mbl_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module mbl_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/multichannel_biquad_lowpass.sv */
// ----------------------------------------------------------------------------
// multichannel_biquad_lowpass: per-channel DF-I low-pass biquad, 2 or 4 order
// Each channel keeps stage-one and stage-two history in two small RAMs.
// A new beat is taken only in S_IDLE, so it waits until the last one has passed the
//   read / multiply / sum-and-write steps of the one shared section datapath (twice
//   with cascade) and S_OUT; a channel number beyond the last channel goes straight
//   to S_OUT with a zero result.
// Reset: coefficients to their defaults, cascade off, history valid bits
//   cleared so every channel's history reads as zero; no RAM clearing pass.
// ----------------------------------------------------------------------------
module multichannel_biquad_lowpass (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  mbl_pkg::in_beat_t                      in_data,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output mbl_pkg::out_beat_t                     out_data,
  // configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [mbl_pkg::CFG_ADDR_W-1:0]         paddr,
  input  logic [mbl_pkg::CFG_DATA_W-1:0]         pwdata,
  output logic [mbl_pkg::CFG_DATA_W-1:0]         prdata,
  output logic                                   pready
);

  import mbl_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_SUM, S_OUT} state_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                     cascade_r;
  logic signed [COEF_W-1:0] coef_b0_r, coef_b1_r, coef_b2_r, coef_a1_r, coef_a2_r;
  reg_idx_t                 cfg_idx;
  logic                     cfg_wr;

  assign cfg_idx = reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cascade_r <= 1'b0;
      coef_b0_r <= B0_RESET;
      coef_b1_r <= B1_RESET;
      coef_b2_r <= B2_RESET;
      coef_a1_r <= A1_RESET;
      coef_a2_r <= A2_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CASCADE: cascade_r <= pwdata[0];
        REG_B0:      coef_b0_r <= pwdata[COEF_W-1:0];
        REG_B1:      coef_b1_r <= pwdata[COEF_W-1:0];
        REG_B2:      coef_b2_r <= pwdata[COEF_W-1:0];
        REG_A1:      coef_a1_r <= pwdata[COEF_W-1:0];
        REG_A2:      coef_a2_r <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // readback, coefficients sign-extended
  always_comb begin
    case (cfg_idx)
      REG_CASCADE: prdata = CFG_DATA_W'(cascade_r);
      REG_B0:      prdata = CFG_DATA_W'(coef_b0_r);
      REG_B1:      prdata = CFG_DATA_W'(coef_b1_r);
      REG_B2:      prdata = CFG_DATA_W'(coef_b2_r);
      REG_A1:      prdata = CFG_DATA_W'(coef_a1_r);
      REG_A2:      prdata = CFG_DATA_W'(coef_a2_r);
      default:     prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control and datapath registers
  // --------------------------------------------------------------------------
  state_t                          state_r;
  logic                            out_valid_r;
  out_beat_t                       out_data_r;
  logic                            stage2_r;
  logic                            ch_ok_r;
  logic [CHAN_W-1:0]               ch_r;
  logic [ADDR_W-1:0]               addr_r;
  logic signed [SAMPLE_WIDTH-1:0]  sx_r;
  logic signed [SAMPLE_WIDTH-1:0]  res_r;
  hist_t                           hcur_r;
  hist_t                           h2_r;
  logic signed [PROD_W-1:0]        p0_r, p1_r, p2_r, p3_r, p4_r;

  logic                            in_ok;
  logic                            in_take;
  logic [ADDR_W-1:0]               in_addr;

  assign in_ready = (state_r == S_IDLE);
  assign in_take  = in_valid && in_ready;
  assign in_ok    = int'(in_data.channel) < CHANNELS;
  assign in_addr  = ADDR_W'(in_data.channel);

  // --------------------------------------------------------------------------
  // History RAMs, one per section; valid bits make unwritten entries zero
  // --------------------------------------------------------------------------
  logic [CHANNELS-1:0] s1_vld_r, s2_vld_r;
  logic [HIST_W-1:0]   rd1, rd2;
  logic                s1_we, s2_we;
  logic                rd_en;
  hist_t               wr_hist;
  hist_t               h1_now, h2_now, hin;

  assign rd_en = in_take && in_ok;
  assign s1_we = (state_r == S_SUM) && !stage2_r;
  assign s2_we = (state_r == S_SUM) && stage2_r;

  mbl_ram #(.WIDTH(HIST_W), .DEPTH(CHANNELS)) u_s1_ram (
    .clk   (clk),
    .we    (s1_we),
    .waddr (addr_r),
    .wdata (wr_hist),
    .re    (rd_en),
    .raddr (in_addr),
    .rdata (rd1)
  );

  mbl_ram #(.WIDTH(HIST_W), .DEPTH(CHANNELS)) u_s2_ram (
    .clk   (clk),
    .we    (s2_we),
    .waddr (addr_r),
    .wdata (wr_hist),
    .re    (rd_en),
    .raddr (in_addr),
    .rdata (rd2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= '0;
      s2_vld_r <= '0;
    end else begin
      if (s1_we) s1_vld_r[addr_r] <= 1'b1;
      if (s2_we) s2_vld_r[addr_r] <= 1'b1;
    end
  end

  assign h1_now = (ch_ok_r && s1_vld_r[addr_r]) ? hist_t'(rd1) : '0;
  assign h2_now = (ch_ok_r && s2_vld_r[addr_r]) ? hist_t'(rd2) : '0;
  // stage two uses the copy taken while stage one ran
  assign hin    = stage2_r ? h2_r : h1_now;

  // --------------------------------------------------------------------------
  // Products (S_MUL), registered
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      p0_r   <= coef_b0_r * sx_r;
      p1_r   <= coef_b1_r * hin.x1;
      p2_r   <= coef_b2_r * hin.x2;
      p3_r   <= coef_a1_r * hin.y1;
      p4_r   <= coef_a2_r * hin.y2;
      hcur_r <= hin;
      if (!stage2_r) h2_r <= h2_now;
    end
  end

  // --------------------------------------------------------------------------
  // Sum, arithmetic shift, saturate (S_SUM)
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0]        acc;
  logic signed [ACC_W-1:0]        acc_sh;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic                           ovf;

  assign acc    = ACC_W'(p0_r) + ACC_W'(p1_r) + ACC_W'(p2_r) - ACC_W'(p3_r) - ACC_W'(p4_r);
  assign acc_sh = acc >>> COEF_FRAC_BITS;
  // out of range when the bits above the sample sign are not all copies of it
  assign ovf    = !((&acc_sh[ACC_W-1:SAMPLE_WIDTH-1]) || !(|acc_sh[ACC_W-1:SAMPLE_WIDTH-1]));

  always_comb begin
    if (!ovf) begin
      y_sat = acc_sh[SAMPLE_WIDTH-1:0];
    end else if (acc_sh[ACC_W-1]) begin
      y_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  assign wr_hist = '{x1: sx_r, x2: hcur_r.x1, y1: y_sat, y2: hcur_r.y1};

  // --------------------------------------------------------------------------
  // Sequencer and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      stage2_r    <= 1'b0;
    end else begin
      // S_OUT refills the output register itself
      if (out_valid_r && out_ready && state_r != S_OUT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ch_r     <= in_data.channel;
            ch_ok_r  <= in_ok;
            addr_r   <= in_addr;
            sx_r     <= in_data.sample_in;
            stage2_r <= 1'b0;
            if (in_ok) begin
              state_r <= S_MUL;
            end else begin
              res_r   <= '0;
              state_r <= S_OUT;
            end
          end
        end
        S_MUL: state_r <= S_SUM;
        S_SUM: begin
          if (!stage2_r && cascade_r) begin
            stage2_r <= 1'b1;
            sx_r     <= y_sat;
            state_r  <= S_MUL;
          end else begin
            res_r   <= y_sat;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{sample_out: res_r, channel_out: ch_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // history is written only for a channel that exists
  a_wr_valid_ch: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_we || s2_we) |-> ch_ok_r)
    else $error("history write for out-of-range channel");

  // stage-two history moves only with the cascade on
  a_s2_cascade: assert property (@(posedge clk) disable iff (!rst_n)
    s2_we |-> cascade_r)
    else $error("stage-two history written with cascade off");

  // a channel beyond the last one skips the datapath
  a_bad_ch_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && !in_ok) |=> (state_r == S_OUT))
    else $error("out-of-range channel entered the datapath");

endmodule

/* tb/sv/tb_multichannel_biquad_lowpass.sv */
// ----------------------------------------------------------------------------
// tb_multichannel_biquad_lowpass: self-checking bench of the biquad low-pass
// Streams channel-tagged samples through the filter under random back
// pressure and checks every result beat against a per-channel fixed-point
// filter model kept in the bench. Coefficients and the cascade switch are
// reprogrammed between phases over the register port, extremes included.
// ----------------------------------------------------------------------------
module tb_multichannel_biquad_lowpass;
  timeunit 1ns;
  timeprecision 1ps;

  import mbl_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_AT_RESULT = 120;
  localparam int HOLD_CYCLES    = 300;
  localparam int UNMAPPED_REG   = REG_A2 + 1;
  localparam int SETTLE_CYCLES  = 8;

  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [COEF_W-1:0]       COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0]       COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};

  // DUT connections
  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_beat_t              in_data  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_beat_t             out_data;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  multichannel_biquad_lowpass dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  // Filter model state: settings and per-channel history of both sections
  logic                       cascade_on;
  logic signed [COEF_W-1:0]   coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  hist_t                      stage1_hist [CHANNELS];
  hist_t                      stage2_hist [CHANNELS];

  in_beat_t  sample_queue [$];
  out_beat_t filtered_queue [$];

  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        mismatch_count = 0;
  int        results_seen = 0;
  int        hold_left = 0;
  int        quiet_cycles = 0;
  logic [CHAN_W-1:0] last_chan = '0;
  out_beat_t want;

  // One DF-I section: exact sum, floor shift, saturate; history advances
  function automatic logic signed [SAMPLE_WIDTH-1:0] biquad_section(
      input logic signed [SAMPLE_WIDTH-1:0] x, inout hist_t h);
    longint acc;
    longint q;
    longint hi = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    longint lo = -hi - 1;
    acc = longint'(coef_b0) * longint'(x) + longint'(coef_b1) * longint'(h.x1)
        + longint'(coef_b2) * longint'(h.x2) - longint'(coef_a1) * longint'(h.y1)
        - longint'(coef_a2) * longint'(h.y2);
    q = acc >>> COEF_FRAC_BITS;
    if (q > hi) q = hi;
    if (q < lo) q = lo;
    h.x2 = h.x1;
    h.x1 = x;
    h.y2 = h.y1;
    h.y1 = SAMPLE_WIDTH'(q);
    return SAMPLE_WIDTH'(q);
  endfunction

  // Expected result of one accepted sample; out-of-range channels give zero
  function automatic out_beat_t filter_predict(input in_beat_t beat);
    out_beat_t r;
    logic signed [SAMPLE_WIDTH-1:0] y;
    y = '0;
    if (beat.channel < CHANNELS) begin
      y = biquad_section(beat.sample_in, stage1_hist[beat.channel]);
      if (cascade_on) y = biquad_section(y, stage2_hist[beat.channel]);
    end
    r.sample_out  = y;
    r.channel_out = beat.channel;
    return r;
  endfunction

  // Register write: setup beat, then access beat; model follows
  task automatic write_reg(input int unsigned idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CASCADE: cascade_on = value[0];
      REG_B0:      coef_b0 = value[COEF_W-1:0];
      REG_B1:      coef_b1 = value[COEF_W-1:0];
      REG_B2:      coef_b2 = value[COEF_W-1:0];
      REG_A1:      coef_a1 = value[COEF_W-1:0];
      REG_A2:      coef_a2 = value[COEF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_coefs(input logic signed [COEF_W-1:0] b0, b1, b2, a1, a2);
    write_reg(REG_B0, CFG_DATA_W'(b0));
    write_reg(REG_B1, CFG_DATA_W'(b1));
    write_reg(REG_B2, CFG_DATA_W'(b2));
    write_reg(REG_A1, CFG_DATA_W'(a1));
    write_reg(REG_A2, CFG_DATA_W'(a2));
  endtask

  task automatic push_sample(input logic signed [SAMPLE_WIDTH-1:0] s,
                             input logic [CHAN_W-1:0] ch);
    in_beat_t b;
    b.sample_in = s;
    b.channel   = ch;
    sample_queue.push_back(b);
  endtask

  // Random samples: extremes, small values, full range; channels run in bursts
  task automatic queue_random(input int n);
    logic signed [SAMPLE_WIDTH-1:0] s;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(7))
        0:       s = SAMPLE_MAX;
        1:       s = SAMPLE_MIN;
        2, 3:    s = SAMPLE_WIDTH'(int'($urandom_range(2000)) - 1000);
        default: s = SAMPLE_WIDTH'($urandom);
      endcase
      if ($urandom_range(1) == 0) begin
        if ($urandom_range(15) == 0) last_chan = CHAN_W'(CHANNELS);
        else last_chan = CHAN_W'($urandom_range(CHANNELS - 1));
      end
      push_sample(s, last_chan);
    end
  endtask

  // Wait for all samples sent and all results back, then let the pipe settle
  task automatic wait_drained();
    do @(negedge clk);
    while (sample_queue.size() != 0 || in_valid || filtered_queue.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Sample driver; prediction at the accepting edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) filtered_queue.push_back(filter_predict(in_data));
      if (!in_valid || in_ready) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= sample_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random stalls and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (filtered_queue.size() == 0) begin
          $error("result beat with no sample pending: channel_out %0d", out_data.channel_out);
          mismatch_count++;
        end else begin
          want = filtered_queue.pop_front();
          if (out_data.sample_out !== want.sample_out) begin
            $error("sample_out: expected %0d, actual %0d", want.sample_out,
                   out_data.sample_out);
            mismatch_count++;
          end
          if (out_data.channel_out !== want.channel_out) begin
            $error("channel_out: expected %0d, actual %0d", want.channel_out,
                   out_data.channel_out);
            mismatch_count++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready && results_seen == HOLD_AT_RESULT) begin
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: too long without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Phases
  initial begin
    cascade_on = 1'b0;
    coef_b0 = B0_RESET;
    coef_b1 = B1_RESET;
    coef_b2 = B2_RESET;
    coef_a1 = A1_RESET;
    coef_a2 = A2_RESET;
    for (int c = 0; c < CHANNELS; c++) begin
      stage1_hist[c] = '0;
      stage2_hist[c] = '0;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings, one section: steps to full scale overshoot and saturate
    send_idle_pct = 30;
    recv_idle_pct = 59;
    repeat (4) push_sample(SAMPLE_MAX, CHAN_W'(0));
    repeat (3) push_sample(SAMPLE_MIN, CHAN_W'(0));
    push_sample('0, CHAN_W'(0));
    for (int i = 0; i < 4; i++) push_sample(i[0] ? SAMPLE_MIN : SAMPLE_MAX, CHAN_W'(1));
    for (int c = 2; c < CHANNELS; c++) push_sample(SAMPLE_WIDTH'(c * 1000 - 3500), CHAN_W'(c));
    // channel number past the last one: no history touched, zero result
    push_sample(SAMPLE_MAX, CHAN_W'(CHANNELS));
    push_sample(SAMPLE_MIN, CHAN_W'(CHANNELS));
    push_sample(SAMPLE_WIDTH'(1), CHAN_W'(0));
    push_sample(SAMPLE_WIDTH'(-1), CHAN_W'(0));
    queue_random(200);
    wait_drained();

    // Cascade on; a write to an unmapped register must change nothing
    write_reg(REG_CASCADE, 1);
    write_reg(UNMAPPED_REG, 32'h0001_FFFF);
    @(negedge clk);
    queue_random(200);
    wait_drained();

    // Coefficient extremes, one section
    write_reg(REG_CASCADE, 0);
    load_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
    @(negedge clk);
    send_idle_pct = 59;
    recv_idle_pct = 30;
    queue_random(150);
    wait_drained();

    // Opposite extremes, cascade back on over stale stage-two history
    write_reg(REG_CASCADE, 1);
    load_coefs(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
    @(negedge clk);
    queue_random(150);
    wait_drained();

    // Nominal low-pass, fourth order
    load_coefs(B0_RESET, B1_RESET, B2_RESET, A1_RESET, A2_RESET);
    @(negedge clk);
    queue_random(300);
    wait_drained();

    // Random coefficients, one section, no idling
    write_reg(REG_CASCADE, 0);
    load_coefs(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
               COEF_W'($urandom), COEF_W'($urandom));
    @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(150);
    wait_drained();

    // Nominal again with the cascade, stage two resumes from frozen history
    write_reg(REG_CASCADE, 1);
    load_coefs(B0_RESET, B1_RESET, B2_RESET, A1_RESET, A2_RESET);
    @(negedge clk);
    queue_random(150);
    wait_drained();

    if (mismatch_count == 0 && filtered_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/mbl_pkg.sv
design/mbl_ram.sv
design/multichannel_biquad_lowpass.sv
tb/sv/tb_multichannel_biquad_lowpass.sv
